/* hw/rtl/sirt_pkg.sv */
// ----------------------------------------------------------------------------
// sirt_pkg
// Shared types and constants for the signed integer to radix text block.
// ----------------------------------------------------------------------------
package sirt_pkg;

	localparam int DIGIT_DEPTH = 32;
	localparam int PADDR_W     = 5;
	localparam int PDATA_W     = 64;

	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_NUL   = 8'h00;

	// register index, taken from paddr[4:3]
	localparam logic [1:0] REG_BASE_LENGTH  = 2'd0;
	localparam logic [1:0] REG_SYMBOLS_LOW  = 2'd1;
	localparam logic [1:0] REG_SYMBOLS_HIGH = 2'd2;

	typedef logic [3:0] digit_t;
	typedef logic [4:0] base_t;

	typedef struct packed {
		digit_t     rem;
		logic [7:0] qbits;
	} div_out_t;

endpackage

/* hw/rtl/sirt_div_step.sv */
// ----------------------------------------------------------------------------
// sirt_div_step
// Shared divide unit: eight restoring steps of a 32-bit value by a base of
// at most 16, consuming one dividend byte per call.
// ----------------------------------------------------------------------------
module sirt_div_step (
	input  sirt_pkg::digit_t   rem_in,
	input  logic [7:0]         bits,
	input  sirt_pkg::base_t    base,
	output sirt_pkg::div_out_t res
);

	always_comb begin
		logic [4:0] trial;
		logic [3:0] r;
		logic [7:0] q;
		r = rem_in;
		q = '0;
		for (int k = 7; k >= 0; k--) begin
			trial = {r, bits[k]};
			if (trial >= base) begin
				trial = trial - base;
				q[k]  = 1'b1;
			end
			// remainder stays below base, so four bits hold it
			r = trial[3:0];
		end
		res.rem   = r;
		res.qbits = q;
	end

endmodule

/* hw/rtl/signed_integer_to_radix_text.sv */
// ----------------------------------------------------------------------------
// signed_integer_to_radix_text
// Converts a signed 32-bit value to text in a configured alphabet, one
// character per output beat, most significant first, last beat flagged.
// ----------------------------------------------------------------------------
//  channel | signals                                   | beat
//  --------+-------------------------------------------+---------------------
//  config  | psel penable pwrite paddr pwdata prdata   | write at access phase
//  input   | in_valid in_ready value                   | one value
//  output  | out_valid out_ready text_char last        | one character
//
// Per value: L = base_length alphabet checks, then for each of D digits four
// passes of the byte-wide divide unit, then D + neg character beats.
// An invalid alphabet ends the value after the alphabet check, no beats.
// Reset clears control state; the digit store holds no reset value.
// The output register stalls the sequencer only during character emission.
// ----------------------------------------------------------------------------
module signed_integer_to_radix_text #(
	parameter int MAX_SYMBOLS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sirt_pkg::PADDR_W-1:0]  paddr,
	input  logic [sirt_pkg::PDATA_W-1:0]  pwdata,
	output logic [sirt_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [31:0]            value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [7:0]                    text_char,
	output logic                          last
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CHECK = 2'd1;
	localparam logic [1:0] ST_DIV   = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	localparam sirt_pkg::base_t MAX_LEN = 5'(MAX_SYMBOLS);

	logic [1:0]              state_q;
	sirt_pkg::base_t         base_len_q;
	logic [63:0]             sym_low_q;
	logic [63:0]             sym_high_q;
	logic [127:0]            sym_all;

	logic [31:0]             quot_q;
	logic [31:0]             qacc_q;
	sirt_pkg::digit_t        rem_q;
	logic [1:0]              step_q;
	logic [5:0]              cnt_q;
	logic                    sign_pend_q;
	logic [3:0]              chk_q;
	logic [5:0]              emit_idx_q;
	sirt_pkg::digit_t        digit_store [sirt_pkg::DIGIT_DEPTH];

	logic                    out_valid_q;
	logic [7:0]              out_char_q;
	logic                    out_last_q;

	logic                    cfg_wr;
	logic                    in_acc;
	logic                    out_free;
	logic [7:0]              chk_sym;
	logic                    chk_dup;
	logic                    chk_bad;
	logic                    len_bad;
	logic [31:0]             next_quot;
	logic [5:0]              emit_prev;
	sirt_pkg::digit_t        emit_digit;
	sirt_pkg::div_out_t      div_res;

	assign sym_all  = {sym_high_q, sym_low_q};
	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign text_char = out_char_q;
	assign last      = out_last_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_len_q <= '0;
			sym_low_q  <= '0;
			sym_high_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[4:3])
				sirt_pkg::REG_BASE_LENGTH:  base_len_q <= pwdata[4:0];
				sirt_pkg::REG_SYMBOLS_LOW:  sym_low_q  <= pwdata;
				sirt_pkg::REG_SYMBOLS_HIGH: sym_high_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:3])
			sirt_pkg::REG_BASE_LENGTH:  prdata = {59'd0, base_len_q};
			sirt_pkg::REG_SYMBOLS_LOW:  prdata = sym_low_q;
			sirt_pkg::REG_SYMBOLS_HIGH: prdata = sym_high_q;
			default:                    prdata = '0;
		endcase
	end

	// alphabet check, one symbol per cycle against all later ones in use
	always_comb begin
		chk_sym = sym_all[{chk_q, 3'b000} +: 8];
		chk_dup = 1'b0;
		for (int j = 0; j < 16; j++) begin
			if ((5'(j) > {1'b0, chk_q}) && (5'(j) < base_len_q) &&
			    (sym_all[j*8 +: 8] == chk_sym))
				chk_dup = 1'b1;
		end
		chk_bad = (chk_sym == sirt_pkg::CHAR_NUL) || (chk_sym == sirt_pkg::CHAR_PLUS) ||
		          (chk_sym == sirt_pkg::CHAR_MINUS) || chk_dup;
		len_bad = (base_len_q < 5'd2) || (base_len_q > MAX_LEN);
	end

	sirt_div_step u_div (
		.rem_in (rem_q),
		.bits   (quot_q[31:24]),
		.base   (base_len_q),
		.res    (div_res)
	);

	assign next_quot  = {qacc_q[23:0], div_res.qbits};
	assign emit_prev  = emit_idx_q - 6'd1;
	assign emit_digit = digit_store[emit_prev[4:0]];

	// digit store, no reset
	always_ff @(posedge clk) begin
		if (state_q == ST_DIV && step_q == 2'd3)
			digit_store[cnt_q[4:0]] <= div_res.rem;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			quot_q      <= '0;
			qacc_q      <= '0;
			cnt_q       <= '0;
			sign_pend_q <= 1'b0;
			chk_q       <= '0;
			step_q      <= '0;
			rem_q       <= '0;
			emit_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_EMIT && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						// value is only held for the accepting edge
						chk_q       <= '0;
						sign_pend_q <= value[31];
						quot_q      <= value[31] ? (32'd0 - value) : value;
						state_q     <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (len_bad || chk_bad) begin
						state_q <= ST_IDLE;
					end else if ({1'b0, chk_q} == base_len_q - 5'd1) begin
						state_q <= ST_DIV;
						cnt_q   <= '0;
						step_q  <= '0;
						rem_q   <= '0;
					end else begin
						chk_q <= chk_q + 4'd1;
					end
				end
				ST_DIV: begin
					step_q <= step_q + 2'd1;
					qacc_q <= next_quot;
					if (step_q == 2'd3) begin
						cnt_q  <= cnt_q + 6'd1;
						quot_q <= next_quot;
						rem_q  <= '0;
						if (next_quot == 32'd0 || cnt_q == 6'(sirt_pkg::DIGIT_DEPTH - 1)) begin
							emit_idx_q <= cnt_q + 6'd1;
							state_q    <= ST_EMIT;
						end
					end else begin
						quot_q <= {quot_q[23:0], 8'd0};
						rem_q  <= div_res.rem;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						if (sign_pend_q) begin
							sign_pend_q <= 1'b0;
						end else begin
							emit_idx_q <= emit_prev;
							if (emit_idx_q == 6'd1)
								state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			if (sign_pend_q) begin
				out_char_q <= sirt_pkg::CHAR_MINUS;
				out_last_q <= 1'b0;
			end else begin
				out_char_q <= sym_all[{emit_digit, 3'b000} +: 8];
				out_last_q <= (emit_idx_q == 6'd1);
			end
		end
	end

	a_accept_to_check: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == ST_CHECK)
		else $error("accepted value did not start the alphabet check");

	a_rem_below_base: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> {1'b0, rem_q} < base_len_q)
		else $error("partial remainder not below base");

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> cnt_q < 6'(sirt_pkg::DIGIT_DEPTH))
		else $error("digit count overran the digit store");

	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> emit_idx_q != 6'd0)
		else $error("emission with no digits left");

	a_done_to_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && step_q == 2'd3 && next_quot == 32'd0) |=> state_q == ST_EMIT)
		else $error("zero quotient did not end the division");

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for signed_integer_to_radix_text. Values are fed over
// the valid/ready input channel. A local predictor works out the expected
// character beats from a shadow of the alphabet registers. Each output beat
// is checked in order against that prediction. The stimulus covers decimal,
// hex and binary text, extreme values, every kind of bad alphabet, and many
// random alphabets. Both sides idle at random, and a long output stall backs
// up the block.
// ----------------------------------------------------------------------------
module testbench;

	localparam int MAX_SYMBOLS  = 16;
	localparam int TAIL_CYCLES  = 250;   // idle tail after each group of values
	localparam int HOLD_CYCLES  = 600;
	localparam int RANDOM_ITEMS = 90;
	localparam logic [1:0] REG_UNMAPPED = 2'd3;

	typedef struct packed {
		logic [7:0] ch;
		logic       lst;
	} text_beat_t;

	logic                           clk;
	logic                           arst_n;
	logic                           psel;
	logic                           penable;
	logic                           pwrite;
	logic [sirt_pkg::PADDR_W-1:0]   paddr;
	logic [sirt_pkg::PDATA_W-1:0]   pwdata;
	logic [sirt_pkg::PDATA_W-1:0]   prdata;
	logic                           pready;
	logic                           in_valid;
	logic                           in_ready;
	logic signed [31:0]             value;
	logic                           out_valid;
	logic                           out_ready;
	logic [7:0]                     text_char;
	logic                           last;

	// shadow of the alphabet registers
	logic [4:0]  cfg_len;
	logic [63:0] cfg_lo;
	logic [63:0] cfg_hi;
	logic [7:0]  alpha [16];

	logic [31:0] value_pending [$];
	text_beat_t  text_expected [$];
	text_beat_t  beat_want;
	logic        in_fire;
	int          fault_count;
	int          src_idle_pct;
	int          snk_idle_pct;
	logic        rx_hold_req;
	int          rx_hold_left;

	signed_integer_to_radix_text #(.MAX_SYMBOLS(MAX_SYMBOLS)) uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .value(value),
		.out_valid(out_valid), .out_ready(out_ready),
		.text_char(text_char), .last(last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [7:0] symbol_of(input logic [3:0] d);
		return d[3] ? cfg_hi[d[2:0]*8 +: 8] : cfg_lo[d[2:0]*8 +: 8];
	endfunction

	function automatic bit alphabet_ok();
		logic [7:0] s;
		if (cfg_len < 2 || cfg_len > MAX_SYMBOLS)
			return 1'b0;
		for (int i = 0; i < cfg_len; i++) begin
			s = symbol_of(4'(i));
			if (s == sirt_pkg::CHAR_NUL || s == sirt_pkg::CHAR_PLUS ||
			    s == sirt_pkg::CHAR_MINUS)
				return 1'b0;
			for (int j = i + 1; j < cfg_len; j++)
				if (symbol_of(4'(j)) == s)
					return 1'b0;
		end
		return 1'b1;
	endfunction

	// queues the characters of v in the current alphabet; bad alphabet gives none
	function automatic void predict_text(input logic [31:0] v);
		logic [31:0] mag;
		logic [31:0] rem;
		logic [3:0]  digs [32];
		int          cnt;
		if (!alphabet_ok())
			return;
		mag = v[31] ? (~v + 32'd1) : v;
		cnt = 0;
		do begin
			rem = mag % 32'(cfg_len);
			digs[cnt] = rem[3:0];
			mag = mag / 32'(cfg_len);
			cnt++;
		end while (mag != 0 && cnt < sirt_pkg::DIGIT_DEPTH);
		if (v[31])
			text_expected.push_back(text_beat_t'{ch: sirt_pkg::CHAR_MINUS, lst: 1'b0});
		for (int i = cnt - 1; i >= 0; i--)
			text_expected.push_back(text_beat_t'{ch: symbol_of(digs[i]), lst: (i == 0)});
	endfunction

	task automatic report_fault(input string msg);
		fault_count++;
		if (fault_count <= 10)
			$display("ERROR @%0t: %s", $time, msg);
	endtask

	task automatic apb_write(input logic [1:0] idx, input logic [63:0] data);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 3'b000};
		pwdata  = data;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (idx)
			sirt_pkg::REG_BASE_LENGTH:  cfg_len = data[4:0];
			sirt_pkg::REG_SYMBOLS_LOW:  cfg_lo  = data;
			sirt_pkg::REG_SYMBOLS_HIGH: cfg_hi  = data;
			default: ;
		endcase
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic commit_alphabet(input int n);
		logic [63:0] w;
		logic [63:0] lo;
		logic [63:0] hi;
		w = {$urandom, $urandom};   // upper bits of base_length are don't-care
		w[4:0] = 5'(n);
		for (int i = 0; i < 8; i++) begin
			lo[i*8 +: 8] = alpha[i];
			hi[i*8 +: 8] = alpha[i+8];
		end
		apb_write(sirt_pkg::REG_BASE_LENGTH, w);
		apb_write(sirt_pkg::REG_SYMBOLS_LOW, lo);
		apb_write(sirt_pkg::REG_SYMBOLS_HIGH, hi);
	endtask

	function automatic void hex_alphabet();
		for (int i = 0; i < 16; i++)
			alpha[i] = (i < 10) ? 8'("0" + i) : 8'("A" + i - 10);
	endfunction

	function automatic void random_alphabet(input int n);
		logic [7:0] s;
		bit         clash;
		for (int i = 0; i < 16; i++) begin
			if (i < n) begin
				do begin
					s = 8'($urandom_range(1, 255));
					clash = (s == sirt_pkg::CHAR_PLUS || s == sirt_pkg::CHAR_MINUS);
					for (int j = 0; j < i; j++)
						if (alpha[j] == s)
							clash = 1'b1;
				end while (clash);
				alpha[i] = s;
			end else
				alpha[i] = 8'($urandom);
		end
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 32'($urandom_range(0, 20));
			1: return 32'(0) - 32'($urandom_range(1, 20));
			2: begin
				case ($urandom_range(0, 3))
					0: return 32'h8000_0000;
					1: return 32'h7FFF_FFFF;
					2: return 32'hFFFF_FFFF;
					default: return 32'h0;
				endcase
			end
			3: return $urandom | 32'h8000_0000;
			default: return $urandom;
		endcase
	endfunction

	// wait until every value is taken and every beat is back, then idle
	task automatic settle(input int tail);
		do
			@(posedge clk);
		while (value_pending.size() != 0 || in_valid || text_expected.size() != 0);
		repeat (tail) @(negedge clk);
	endtask

	task automatic bad_alphabet_case(input int n, input logic [31:0] v);
		commit_alphabet(n);
		value_pending.push_back(v);
		settle(TAIL_CYCLES);
	endtask

	// input driver
	always @(negedge clk) begin
		if (!in_valid || in_fire) begin
			if (arst_n && value_pending.size() != 0 &&
			    $urandom_range(0, 99) >= src_idle_pct) begin
				in_valid <= 1'b1;
				value    <= value_pending.pop_front();
			end else
				in_valid <= 1'b0;
		end
	end

	// long output stall, started once by the stimulus
	always @(negedge clk) begin
		if (rx_hold_req)
			rx_hold_left <= HOLD_CYCLES;
		else if (rx_hold_left != 0)
			rx_hold_left <= rx_hold_left - 1;
	end

	always @(negedge clk)
		out_ready <= (rx_hold_left == 0) && ($urandom_range(0, 99) >= snk_idle_pct);

	// monitor
	always @(posedge clk) begin
		in_fire <= in_valid && in_ready;
		if (arst_n) begin
			if (in_valid && in_ready)
				predict_text(value);
			if (out_valid && out_ready) begin
				if (text_expected.size() == 0) begin
					report_fault($sformatf("unexpected beat: char %h last %b",
						text_char, last));
				end else begin
					beat_want = text_expected.pop_front();
					if (beat_want.ch !== text_char || beat_want.lst !== last)
						report_fault($sformatf("char exp %h got %h, last exp %b got %b",
							beat_want.ch, text_char, beat_want.lst, last));
				end
			end
		end
	end

	initial begin
		#3_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int  n;
		int  cnt;
		int  phase;
		int  rand_items;
		int  idx;
		bit  bad;

		clk          = 1'b0;
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		in_valid     = 1'b0;
		value        = '0;
		out_ready    = 1'b0;
		in_fire      = 1'b0;
		rx_hold_req  = 1'b0;
		rx_hold_left = 0;
		fault_count  = 0;
		src_idle_pct = 21;
		snk_idle_pct = 21;
		cfg_len      = '0;
		cfg_lo       = '0;
		cfg_hi       = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset alphabet is empty, so nothing comes out
		value_pending.push_back(32'd5);
		settle(TAIL_CYCLES);

		// writes to an unmapped register are dropped
		apb_write(REG_UNMAPPED, {$urandom, $urandom});

		// decimal; the unused slots hold illegal symbols that must be ignored
		hex_alphabet();
		alpha[10] = sirt_pkg::CHAR_MINUS;
		alpha[11] = sirt_pkg::CHAR_PLUS;
		alpha[12] = sirt_pkg::CHAR_NUL;
		alpha[13] = "0";
		commit_alphabet(10);
		value_pending = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10,
			-32'sd10, 32'h7FFF_FFFF, 32'h8000_0000};
		settle(TAIL_CYCLES);

		hex_alphabet();
		commit_alphabet(16);
		value_pending = '{32'd15, 32'd16, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001};
		settle(TAIL_CYCLES);

		// binary: most negative value gives the longest text
		commit_alphabet(2);
		value_pending = '{32'h8000_0000, 32'h7FFF_FFFF, 32'd2, -32'sd3};
		settle(TAIL_CYCLES);

		bad_alphabet_case(1, 32'd7);
		bad_alphabet_case(17, 32'd7);
		hex_alphabet();
		alpha[4] = sirt_pkg::CHAR_PLUS;
		bad_alphabet_case(10, 32'd123);
		hex_alphabet();
		alpha[15] = sirt_pkg::CHAR_MINUS;
		bad_alphabet_case(16, -32'sd45);
		hex_alphabet();
		alpha[9] = sirt_pkg::CHAR_NUL;
		bad_alphabet_case(10, 32'd99);
		hex_alphabet();
		alpha[7] = alpha[2];
		bad_alphabet_case(8, 32'd64);

		rand_items = 0;
		phase = 0;
		while (rand_items < RANDOM_ITEMS) begin
			n = (phase == 0) ? 16 : (phase == 1) ? 2 : $urandom_range(2, 16);
			random_alphabet(n);
			bad = (phase > 3) && ($urandom_range(0, 5) == 0);
			if (bad) begin
				idx = $urandom_range(0, n - 1);
				case ($urandom_range(0, 3))
					0: alpha[idx] = sirt_pkg::CHAR_PLUS;
					1: alpha[idx] = sirt_pkg::CHAR_MINUS;
					2: alpha[idx] = sirt_pkg::CHAR_NUL;
					default: alpha[n-1] = alpha[0];
				endcase
			end
			commit_alphabet(n);
			src_idle_pct = (phase == 2 || phase == 3) ? 0 : 21;
			snk_idle_pct = (phase == 2) ? 0 : 21;
			if (phase == 3) begin
				@(posedge clk);
				rx_hold_req = 1'b1;
				@(posedge clk);
				rx_hold_req = 1'b0;
			end
			cnt = bad ? 3 : (phase == 3) ? 16 : 15;
			for (int k = 0; k < cnt; k++) begin
				// sender waits for every beat to come back half way through
				if (k == cnt / 2 && phase % 3 == 1)
					settle(0);
				value_pending.push_back(pick_value());
			end
			settle(TAIL_CYCLES);
			if (!bad)
				rand_items += cnt;
			phase++;
		end

		if (fault_count == 0 && text_expected.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* files.f */
hw/rtl/sirt_pkg.sv
hw/rtl/sirt_div_step.sv
hw/rtl/signed_integer_to_radix_text.sv
verif/testbench.sv
